// File: hw/rtl/fds_pkg.sv
`timescale 1ns / 1ps
// fds_pkg: shared types and constants for the forth data stack
// payload structs, command and error codes, controller state type; no dependencies

package fds_pkg;

   localparam int unsigned CMD_W   = 4;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned TAG_W   = 2;
   localparam int unsigned ERR_W   = 2;
   localparam int unsigned DEPTH_W = 9;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK  = 4'd2;
   localparam logic [CMD_W-1:0] CMD_DUP   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_OVER  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_TUCK  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_SWAP  = 4'd6;
   localparam logic [CMD_W-1:0] CMD_DROP  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 4'd8;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] item_value;
      logic [TAG_W-1:0]   item_tag;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [TAG_W-1:0]   read_tag;
      logic [ERR_W-1:0]   error_code;
      logic [DEPTH_W-1:0] depth_now;
      logic               is_empty;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RDB,
      S_EXEC,
      S_WR2,
      S_WR3,
      S_DONE
   } state_type;

   // number of elements a command needs on the stack
   function automatic logic [1:0] cmd_need(input logic [CMD_W-1:0] cmd);
      logic [1:0] need;
      need = 2'd0;
      if (cmd == CMD_POP || cmd == CMD_PEEK || cmd == CMD_DUP || cmd == CMD_DROP) begin
         need = 2'd1;
      end else if (cmd == CMD_OVER || cmd == CMD_TUCK || cmd == CMD_SWAP) begin
         need = 2'd2;
      end
      return need;
   endfunction

   // command adds one element
   function automatic logic cmd_grows(input logic [CMD_W-1:0] cmd);
      return (cmd == CMD_PUSH || cmd == CMD_DUP || cmd == CMD_OVER || cmd == CMD_TUCK);
   endfunction

endpackage

// File: hw/rtl/forth_data_stack.sv
`timescale 1ns / 1ps
// forth_data_stack: tagged-word data stack built around one single-port-write memory
// depends on fds_pkg (payload structs, command and error codes, state type)

// One command per transfer on req_, one result per command on rsp_. Elements live
// in a DEPTH-entry memory with registered read data; a small sequencer reads the
// top one or two entries as the command needs, writes back and then posts the result.
// Push, pop, peek, dup, drop, clear, unknown codes and any command that underflows
// or overflows go from the transfer straight to the execute state; over, swap and
// tuck first read the second entry, and swap and tuck then take extra write states,
// as the single write port serializes the two or three write-backs of swap and tuck.
// A finished result sits in an output register, so the next command is taken while
// it waits; the sequencer only stalls when a second result is ready before the
// first is taken. The memory needs no clearing after reset: only entries below the
// element count are ever read, and all of those have been written.

module forth_data_stack
   import fds_pkg::*;
#(
   parameter int unsigned DEPTH      = 256,
   parameter int unsigned WORD_WIDTH = 64
) (
   input  logic    clock,
   input  logic    reset,

   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,

   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // memory address
   localparam int unsigned CW = $clog2(DEPTH + 1);                // element count
   localparam int unsigned EW = WORD_WIDTH + TAG_W;               // stored entry

   // element memory: {tag, word}, undefined until written
   logic [EW-1:0] mem [DEPTH];

   // sequencer state
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;

   // latched command
   logic [CMD_W-1:0]      cmd_ff;
   logic [WORD_WIDTH-1:0] value_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [ERR_W-1:0]      err_ff, err_in;

   // memory read path
   logic          mem_re;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] mem_rd_ff;

   // memory write path
   logic          mem_we;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   // top element held while the second one is read
   logic          a_load;
   logic [EW-1:0] a_ff;

   // result register
   logic    rsp_valid_ff;
   logic    rsp_load;
   rsp_type rsp_in, rsp_payload_ff;

   // helpers
   logic          req_xfer;
   logic          slot_free;
   logic [1:0]    req_need;
   logic [1:0]    ff_need;
   logic          cmd_ok;
   logic [EW-1:0] a_val;
   logic [EW-1:0] b_val;
   logic [AW-1:0] addr_top;   // count - 1
   logic [AW-1:0] addr_sec;   // count - 2
   logic [AW-1:0] addr_new;   // count, the slot above the top

   assign req_xfer  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_need  = cmd_need(req_payload.cmd);
   assign ff_need   = cmd_need(cmd_ff);
   assign cmd_ok    = (err_ff == ERR_OK);

   assign addr_top = AW'(count_ff - CW'(1));
   assign addr_sec = AW'(count_ff - CW'(2));
   assign addr_new = AW'(count_ff);

   // top element comes straight from the read register unless the second read replaced it
   assign a_val = (ff_need == 2'd2) ? a_ff : mem_rd_ff;
   assign b_val = mem_rd_ff;

   // underflow is checked before overflow
   always_comb begin
      priority if (count_ff < CW'(req_need)) begin
         err_in = ERR_UNDER;
      end else if (cmd_grows(req_payload.cmd) && count_ff >= CW'(DEPTH)) begin
         err_in = ERR_OVER;
      end else begin
         err_in = ERR_OK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = (err_in == ERR_OK && req_need == 2'd2) ? S_RDB : S_EXEC;
            end
         end
         S_RDB: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = (cmd_ok && (cmd_ff == CMD_SWAP || cmd_ff == CMD_TUCK)) ? S_WR2 : S_DONE;
         end
         S_WR2: begin
            state_in = (cmd_ff == CMD_TUCK) ? S_WR3 : S_DONE;
         end
         S_WR3: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      mem_re    = 1'b0;
      rd_addr   = addr_top;
      a_load    = 1'b0;
      mem_we    = 1'b0;
      wr_addr   = addr_new;
      wr_data   = a_val;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            mem_re    = req_valid && (err_in == ERR_OK) && (req_need != 2'd0);
         end
         S_RDB: begin
            mem_re  = 1'b1;
            rd_addr = addr_sec;
            a_load  = 1'b1;
         end
         S_EXEC: begin
            if (cmd_ok) begin
               priority if (cmd_ff == CMD_PUSH) begin
                  mem_we  = 1'b1;
                  wr_data = {tag_ff, value_ff};
               end else if (cmd_ff == CMD_DUP) begin
                  mem_we  = 1'b1;
               end else if (cmd_ff == CMD_OVER) begin
                  mem_we  = 1'b1;
                  wr_data = b_val;
               end else if (cmd_ff == CMD_SWAP || cmd_ff == CMD_TUCK) begin
                  mem_we  = 1'b1;
                  wr_addr = addr_sec;
               end else begin
                  mem_we  = 1'b0;
               end
            end
         end
         S_WR2: begin
            mem_we  = 1'b1;
            wr_addr = addr_top;
            wr_data = b_val;
         end
         S_WR3: begin
            mem_we  = 1'b1;
            wr_data = a_ff;
         end
         S_DONE: begin
            rsp_load = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // count after the step
   always_comb begin
      count_in = count_ff;
      if (cmd_ok) begin
         priority if (cmd_grows(cmd_ff)) begin
            count_in = count_ff + CW'(1);
         end else if (cmd_ff == CMD_POP || cmd_ff == CMD_DROP) begin
            count_in = count_ff - CW'(1);
         end else if (cmd_ff == CMD_CLEAR) begin
            count_in = '0;
         end else begin
            count_in = count_ff;
         end
      end
   end

   // result fields; only pop and peek return an element
   always_comb begin
      rsp_in = '0;
      if (cmd_ok && (cmd_ff == CMD_POP || cmd_ff == CMD_PEEK)) begin
         rsp_in.read_value = VALUE_W'(mem_rd_ff[WORD_WIDTH-1:0]);
         rsp_in.read_tag   = mem_rd_ff[EW-1:WORD_WIDTH];
      end
      rsp_in.error_code = err_ff;
      rsp_in.depth_now  = DEPTH_W'(count_in);
      rsp_in.is_empty   = (count_in == '0);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff   <= req_payload.cmd;
         value_ff <= req_payload.item_value[WORD_WIDTH-1:0];
         tag_ff   <= req_payload.item_tag;
         err_ff   <= err_in;
      end
      if (a_load) begin
         a_ff <= mem_rd_ff;
      end
      if (rsp_load) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   // element memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTH
   // element count never passes the capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count above capacity");

   // a transfer always starts a sequence
   a_xfer_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after a command transfer");

   // a pending result is never overwritten
   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_ready) |=> state_ff == S_DONE)
      else $error("result posted over an untaken result");

   // failed commands leave the depth alone
   a_err_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && err_ff != ERR_OK) |=> count_ff == $past(count_ff))
      else $error("failed command changed the element count");

   // empty flag agrees with the posted depth
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_payload_ff.is_empty == (rsp_payload_ff.depth_now == '0))
      else $error("empty flag disagrees with depth");
`endif

endmodule

// File: test/stack_checker.sv
`timescale 1ns / 1ps
// stack_checker: watches the command and result channels of forth_data_stack,
// keeps its own copy of the stack and compares every result; depends on fds_pkg

module stack_checker
   import fds_pkg::*;
#(
   parameter int unsigned DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_payload,
   output int unsigned mismatch_count,
   output int unsigned pending_count,
   output int unsigned results_checked,
   output int unsigned underflows_seen,
   output int unsigned overflows_seen
);

   localparam int unsigned MAX_PRINTED = 40;

   // shadow stack: word in the upper bits, tag in the lowest two
   logic [VALUE_W+TAG_W-1:0] shadow_words [0:DEPTH-1];
   int unsigned              shadow_count;

   rsp_type     expected_results [$];
   rsp_type     want;
   int unsigned mismatch_total;
   int unsigned checked_total;
   int unsigned under_total;
   int unsigned over_total;

   task automatic report_mismatch(input string field_name, input logic [63:0] got,
                                  input logic [63:0] wanted);
      mismatch_total++;
      if (mismatch_total <= MAX_PRINTED) begin
         $display("[%0t] MISMATCH %s after %0d results: got %0h, expected %0h", $realtime,
                  field_name, checked_total, got, wanted);
      end
   endtask

   // applies one command to the shadow stack and returns the result it should give
   function automatic rsp_type apply_command(input req_type item);
      rsp_type                  res;
      int unsigned              need;
      logic                     grows;
      logic [VALUE_W+TAG_W-1:0] top_cell;
      logic [VALUE_W+TAG_W-1:0] second_cell;
      res         = '0;
      need        = 0;
      grows       = 1'b0;
      top_cell    = '0;
      second_cell = '0;
      case (item.cmd)
         CMD_PUSH: grows = 1'b1;
         CMD_POP, CMD_PEEK, CMD_DROP: need = 1;
         CMD_DUP: begin
            need  = 1;
            grows = 1'b1;
         end
         CMD_OVER, CMD_TUCK: begin
            need  = 2;
            grows = 1'b1;
         end
         CMD_SWAP: need = 2;
         default: ;
      endcase

      if (shadow_count < need) begin
         res.error_code = ERR_UNDER;
      end else if (grows && shadow_count >= DEPTH) begin
         res.error_code = ERR_OVER;
      end else begin
         if (shadow_count >= 1) top_cell = shadow_words[shadow_count-1];
         if (shadow_count >= 2) second_cell = shadow_words[shadow_count-2];
         case (item.cmd)
            CMD_PUSH: begin
               shadow_words[shadow_count] = {item.item_value, item.item_tag};
               shadow_count++;
            end
            CMD_POP: begin
               {res.read_value, res.read_tag} = top_cell;
               shadow_count--;
            end
            CMD_PEEK: {res.read_value, res.read_tag} = top_cell;
            CMD_DUP: begin
               shadow_words[shadow_count] = top_cell;
               shadow_count++;
            end
            CMD_OVER: begin
               shadow_words[shadow_count] = second_cell;
               shadow_count++;
            end
            CMD_TUCK: begin
               // a b -- b a b
               shadow_words[shadow_count-2] = top_cell;
               shadow_words[shadow_count-1] = second_cell;
               shadow_words[shadow_count]   = top_cell;
               shadow_count++;
            end
            CMD_SWAP: begin
               shadow_words[shadow_count-2] = top_cell;
               shadow_words[shadow_count-1] = second_cell;
            end
            CMD_DROP: shadow_count--;
            CMD_CLEAR: shadow_count = 0;
            default: ;
         endcase
      end
      res.depth_now = shadow_count[DEPTH_W-1:0];
      res.is_empty  = (shadow_count == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         shadow_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_payload.read_value, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_payload.read_value, want.read_value);
               if (rsp_payload.read_tag !== want.read_tag)
                  report_mismatch("read_tag", rsp_payload.read_tag, want.read_tag);
               if (rsp_payload.error_code !== want.error_code)
                  report_mismatch("error_code", rsp_payload.error_code, want.error_code);
               if (rsp_payload.depth_now !== want.depth_now)
                  report_mismatch("depth_now", rsp_payload.depth_now, want.depth_now);
               if (rsp_payload.is_empty !== want.is_empty)
                  report_mismatch("is_empty", rsp_payload.is_empty, want.is_empty);
               if (want.error_code == ERR_UNDER) under_total++;
               if (want.error_code == ERR_OVER) over_total++;
               checked_total++;
            end
         end
         if (req_valid && req_ready) begin
            expected_results.insert(expected_results.size(), apply_command(req_payload));
         end
      end
      mismatch_count  <= mismatch_total;
      pending_count   <= expected_results.size();
      results_checked <= checked_total;
      underflows_seen <= under_total;
      overflows_seen  <= over_total;
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// testbench: command stimulus and verdict for forth_data_stack
// depends on fds_pkg, forth_data_stack and stack_checker

module testbench;
   import fds_pkg::*;

   localparam int unsigned STACK_DEPTH  = 256;
   localparam int unsigned RANDOM_ITEMS = 1800;
   localparam int unsigned FIRST_FILL   = 350;   // long enough to reach a full stack
   localparam int unsigned QUIET_TAIL   = 200;   // last transfers run without idling
   localparam int unsigned TAIL_CYCLES  = 20;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   // codes outside the command set, the block must ignore them
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

   // flavor of a random stretch of commands
   typedef enum int {
      MODE_MIXED,
      MODE_FILL,
      MODE_DRAIN,
      MODE_NOISE
   } mode_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned results_checked;
   int unsigned underflows_seen;
   int unsigned overflows_seen;

   int unsigned cycle_count    = 0;
   int unsigned commands_sent  = 0;
   int unsigned random_sent    = 0;
   int unsigned chunk_len      = 0;
   int unsigned stall_left     = 0;
   bit          idle_on        = 1'b1;
   mode_type    mode;

   forth_data_stack #(
      .DEPTH      (STACK_DEPTH),
      .WORD_WIDTH (VALUE_W)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // the checker sees both channels and owns the prediction
   stack_checker #(
      .DEPTH (STACK_DEPTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .underflows_seen (underflows_seen),
      .overflows_seen  (overflows_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending", cycle_count,
                  pending_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: ready drops in bursts of random length while idling is on
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic req_type make_req(input logic [CMD_W-1:0] cmd,
                                        input logic [VALUE_W-1:0] value,
                                        input logic [TAG_W-1:0] tag);
      req_type item;
      item.cmd        = cmd;
      item.item_value = value;
      item.item_tag   = tag;
      return item;
   endfunction

   // random command weighted by the stretch flavor; value and tag are random
   // for every command since the block must ignore them outside push
   function automatic req_type random_command(input mode_type flavor);
      req_type     item;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 15))
         0:       item.item_value = '0;
         1:       item.item_value = '1;
         default: item.item_value = {$urandom, $urandom};
      endcase
      item.item_tag = TAG_W'($urandom_range(0, 3));
      case (flavor)
         MODE_FILL: begin
            // mostly growing commands, pushes the stack into overflow
            if (roll < 60)      item.cmd = CMD_PUSH;
            else if (roll < 70) item.cmd = CMD_DUP;
            else if (roll < 80) item.cmd = CMD_OVER;
            else if (roll < 88) item.cmd = CMD_TUCK;
            else if (roll < 92) item.cmd = CMD_SWAP;
            else if (roll < 95) item.cmd = CMD_PEEK;
            else if (roll < 98) item.cmd = CMD_POP;
            else                item.cmd = CMD_DROP;
         end
         MODE_DRAIN: begin
            // shrinking stack, lots of underflow near the bottom
            if (roll < 15)      item.cmd = CMD_PUSH;
            else if (roll < 50) item.cmd = CMD_POP;
            else if (roll < 75) item.cmd = CMD_DROP;
            else if (roll < 80) item.cmd = CMD_PEEK;
            else if (roll < 85) item.cmd = CMD_SWAP;
            else if (roll < 90) item.cmd = CMD_DUP;
            else if (roll < 94) item.cmd = CMD_OVER;
            else if (roll < 98) item.cmd = CMD_TUCK;
            else                item.cmd = CMD_CLEAR;
         end
         MODE_NOISE: item.cmd = CMD_W'($urandom_range(0, 15));
         default: begin
            if (roll < 30)      item.cmd = CMD_PUSH;
            else if (roll < 45) item.cmd = CMD_POP;
            else if (roll < 53) item.cmd = CMD_PEEK;
            else if (roll < 61) item.cmd = CMD_DUP;
            else if (roll < 69) item.cmd = CMD_OVER;
            else if (roll < 77) item.cmd = CMD_TUCK;
            else if (roll < 85) item.cmd = CMD_SWAP;
            else if (roll < 95) item.cmd = CMD_DROP;
            else if (roll < 97) item.cmd = CMD_CLEAR;
            else item.cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
         end
      endcase
      return item;
   endfunction

   // one command transfer; valid stays high after the transfer so that
   // back-to-back commands never see valid drop and rise in one step
   task automatic send_command(input req_type item);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      commands_sent++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: all but tuck on an empty stack, then over, tuck and swap on one element
      send_command(make_req(CMD_POP, '1, 2'd3));
      send_command(make_req(CMD_PEEK, '0, 2'd0));
      send_command(make_req(CMD_DUP, '0, 2'd0));
      send_command(make_req(CMD_DROP, '0, 2'd0));
      send_command(make_req(CMD_OVER, '0, 2'd0));
      send_command(make_req(CMD_SWAP, '0, 2'd0));
      send_command(make_req(CMD_CLEAR, '0, 2'd0));
      send_command(make_req(CMD_PUSH, '0, 2'd0));
      send_command(make_req(CMD_OVER, '0, 2'd0));
      send_command(make_req(CMD_TUCK, '0, 2'd0));
      send_command(make_req(CMD_SWAP, '0, 2'd0));
      // value extremes and all four tags, tag 3 included
      send_command(make_req(CMD_PUSH, '1, 2'd3));
      send_command(make_req(CMD_PUSH, 64'h8000_0000_0000_0001, 2'd1));
      send_command(make_req(CMD_PUSH, 64'h5a5a_a5a5_0f0f_f0f0, 2'd2));
      send_command(make_req(CMD_PEEK, '1, 2'd1));
      send_command(make_req(CMD_DUP, '0, 2'd0));
      send_command(make_req(CMD_OVER, '0, 2'd0));
      send_command(make_req(CMD_TUCK, '0, 2'd0));
      send_command(make_req(CMD_SWAP, '0, 2'd0));
      // unknown codes at both ends of the unused range
      send_command(make_req(CMD_UNUSED_LO, '1, 2'd3));
      send_command(make_req(CMD_UNUSED_HI, {$urandom, $urandom}, 2'd2));
      send_command(make_req(CMD_POP, '0, 2'd0));
      send_command(make_req(CMD_DROP, '0, 2'd0));
      send_command(make_req(CMD_CLEAR, '0, 2'd0));
      send_command(make_req(CMD_POP, '0, 2'd0));

      // random: a long fill first so overflow is reached, then stretches of
      // random flavor and length, each with idling on or off
      mode      = MODE_FILL;
      chunk_len = FIRST_FILL;
      while (random_sent < RANDOM_ITEMS) begin
         for (int i = 0; i < chunk_len && random_sent < RANDOM_ITEMS; i++) begin
            if (random_sent >= RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
            send_command(random_command(mode));
            random_sent++;
         end
         mode      = mode_type'($urandom_range(0, 3));
         chunk_len = $urandom_range(40, 200);
         if (random_sent < RANDOM_ITEMS - QUIET_TAIL) idle_on = ($urandom_range(0, 3) != 0);
      end
      req_valid <= 1'b0;

      // the checker counts are registered and lag the transfers, so wait for a clock edge before polling them
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d commands sent, %0d results checked in %0d cycles", commands_sent,
               results_checked, cycle_count);
      $display("%0d underflow and %0d overflow outcomes, %0d mismatches", underflows_seen,
               overflows_seen, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: forth_data_stack.f
hw/rtl/fds_pkg.sv
hw/rtl/forth_data_stack.sv
test/stack_checker.sv
test/testbench.sv
